// File: hw/rtl/olst_pkg.sv
package olst_pkg;

  localparam int unsigned CAPACITY  = 64;
  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned FUNC_W    = 4;
  localparam int unsigned IDX_W     = 6;
  localparam int unsigned CNT_W     = 7;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned GROUP     = 8;
  localparam int unsigned NGROUP    = CAPACITY / GROUP;
  localparam int unsigned GRP_IDX_W = $clog2(GROUP);

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  typedef enum logic [FUNC_W-1:0] {
    F_PUSH     = 4'd0,
    F_POP      = 4'd1,
    F_GET      = 4'd2,
    F_SET      = 4'd3,
    F_INSERT   = 4'd4,
    F_REMOVE   = 4'd5,
    F_SWAP     = 4'd6,
    F_MOVE     = 4'd7,
    F_FIND     = 4'd8,
    F_SETCOUNT = 4'd9,
    F_CLEAR    = 4'd10
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_BAD_INDEX = 3'd1,
    ST_FULL      = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE    = 4'b0001,
    S_GATHER  = 4'b0010,
    S_RESOLVE = 4'b0100,
    S_COMMIT  = 4'b1000
  } state_t;

  // Broadcast to every cell for the lookup pass.
  typedef struct packed {
    logic [VALUE_W-1:0] key;
    logic [CNT_W-1:0]   rda_idx;
    logic [IDX_W-1:0]   rdb_idx;
    logic [CNT_W-1:0]   count;
  } cell_look_t;

  // Per-cell lookup flags.
  typedef struct packed {
    logic hit;
    logic sel_a;
    logic sel_b;
  } cell_flags_t;

  // Broadcast to every cell for the update pass.
  typedef struct packed {
    logic               wr_en;
    logic               take_left;
    logic               take_right;
    logic [CNT_W-1:0]   lo;
    logic [CNT_W-1:0]   hi_x;
    logic               load0_en;
    logic [IDX_W-1:0]   load0_idx;
    logic [VALUE_W-1:0] load0_val;
    logic               load1_en;
    logic [IDX_W-1:0]   load1_idx;
    logic [VALUE_W-1:0] load1_val;
  } cell_ctrl_t;

  typedef struct packed {
    logic [VALUE_W-1:0]   val_a;
    logic [VALUE_W-1:0]   val_b;
    logic                 hit;
    logic [GRP_IDX_W-1:0] hit_pos;
  } grp_res_t;

endpackage

// File: hw/rtl/ordered_list_engine_top.sv
// Ordered list engine: 64 x 32-bit list held in a chain of cells.
// A request passes the gather, resolve and commit states; the result is registered
// at commit. A new request is taken only once the last one commits, as the two-level
// registered read/find tree lies before the commit step, which a stalled result holds.
// Reset (synchronous, rst_n low): all entries zero, count zero, no result pending.
module ordered_list_engine_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [olst_pkg::FUNC_W-1:0]     in_func,
  input  logic [olst_pkg::CNT_W-1:0]      in_first_index,
  input  logic [olst_pkg::IDX_W-1:0]      in_second_index,
  input  logic [olst_pkg::VALUE_W-1:0]    in_elem_value,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [olst_pkg::STATUS_W-1:0]   out_status,
  output logic [olst_pkg::VALUE_W-1:0]    out_read_value,
  output logic [olst_pkg::IDX_W-1:0]      out_position,
  output logic [olst_pkg::CNT_W-1:0]      out_entry_total
);

  olst_pkg::state_t state_r, state_nxt;

  // Request registers, loaded on the input transfer.
  olst_pkg::func_t              func_r;
  logic [olst_pkg::CNT_W-1:0]   a_r;
  logic [olst_pkg::IDX_W-1:0]   b_r;
  logic [olst_pkg::VALUE_W-1:0] v_r;
  logic [olst_pkg::CNT_W-1:0]   rda_r;

  logic [olst_pkg::CNT_W-1:0]   count_r, count_nxt;

  // Resolved read values and find result.
  logic [olst_pkg::VALUE_W-1:0] tmp_a_r, tmp_a_nxt;
  logic [olst_pkg::VALUE_W-1:0] tmp_b_r, tmp_b_nxt;
  logic                         hit_r, hit_nxt;
  logic [olst_pkg::IDX_W-1:0]   hit_pos_r, hit_pos_nxt;

  // Result register.
  logic                            out_valid_r, out_valid_nxt;
  logic [olst_pkg::STATUS_W-1:0]   status_r, status_nxt;
  logic [olst_pkg::VALUE_W-1:0]    rd_r, rd_nxt;
  logic [olst_pkg::IDX_W-1:0]      pos_r, pos_nxt;

  logic in_xfer;
  logic commit_go;

  olst_pkg::cell_look_t look;
  olst_pkg::cell_ctrl_t ctrl;

  logic [olst_pkg::CAPACITY-1:0][olst_pkg::VALUE_W-1:0] cell_val;
  olst_pkg::cell_flags_t [olst_pkg::CAPACITY-1:0]        cell_flg;
  olst_pkg::grp_res_t                                    grp_res [olst_pkg::NGROUP];

  assign in_stall  = (state_r != olst_pkg::S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  // Hold the commit step while the previous result still waits.
  assign commit_go = (state_r == olst_pkg::S_COMMIT) && !(out_valid_r && out_stall);

  assign look.key     = v_r;
  assign look.rda_idx = rda_r;
  assign look.rdb_idx = b_r;
  assign look.count   = count_r;

  // Chain of cells: each cell sees its neighbors for shifting.
  for (genvar k = 0; k < olst_pkg::CAPACITY; k++) begin : g_cell
    localparam int unsigned CI = k;
    logic [olst_pkg::VALUE_W-1:0] left_w;
    logic [olst_pkg::VALUE_W-1:0] right_w;
    if (k == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_left
      assign left_w = cell_val[k-1];
    end
    if (k == olst_pkg::CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_right
      assign right_w = cell_val[k+1];
    end
    olst_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cell_idx  (CI[olst_pkg::IDX_W-1:0]),
      .look      (look),
      .ctrl      (ctrl),
      .left_val  (left_w),
      .right_val (right_w),
      .val       (cell_val[k]),
      .flags     (cell_flg[k])
    );
  end

  // First level of the read/find tree, one group of cells each.
  for (genvar g = 0; g < olst_pkg::NGROUP; g++) begin : g_grp
    olst_group u_group (
      .clk   (clk),
      .vals  (cell_val[g*olst_pkg::GROUP +: olst_pkg::GROUP]),
      .flags (cell_flg[g*olst_pkg::GROUP +: olst_pkg::GROUP]),
      .res   (grp_res[g])
    );
  end

  // Second level: merge the groups, lowest group hit wins.
  always_comb begin
    tmp_a_nxt   = '0;
    tmp_b_nxt   = '0;
    hit_nxt     = 1'b0;
    hit_pos_nxt = '0;
    for (int g = olst_pkg::NGROUP - 1; g >= 0; g--) begin
      tmp_a_nxt = tmp_a_nxt | grp_res[g].val_a;
      tmp_b_nxt = tmp_b_nxt | grp_res[g].val_b;
      if (grp_res[g].hit) begin
        hit_nxt     = 1'b1;
        hit_pos_nxt = olst_pkg::IDX_W'(g * olst_pkg::GROUP + int'(grp_res[g].hit_pos));
      end
    end
  end

  // Commit: status, new count, and the update broadcast to the cells.
  always_comb begin
    status_nxt = olst_pkg::ST_OK;
    rd_nxt     = '0;
    pos_nxt    = '0;
    count_nxt  = count_r;
    ctrl       = '0;
    ctrl.wr_en = commit_go;
    case (func_r)
      olst_pkg::F_PUSH: begin
        if (count_r >= olst_pkg::CAP_CNT) begin
          status_nxt = olst_pkg::ST_FULL;
        end else begin
          ctrl.load0_en  = 1'b1;
          ctrl.load0_idx = count_r[olst_pkg::IDX_W-1:0];
          ctrl.load0_val = v_r;
          pos_nxt        = count_r[olst_pkg::IDX_W-1:0];
          count_nxt      = count_r + olst_pkg::CNT_W'(1);
        end
      end
      olst_pkg::F_POP: begin
        if (count_r == '0) begin
          status_nxt = olst_pkg::ST_EMPTY;
        end else begin
          rd_nxt    = tmp_a_r;
          count_nxt = count_r - olst_pkg::CNT_W'(1);
        end
      end
      olst_pkg::F_GET: begin
        if (a_r >= count_r) begin
          status_nxt = olst_pkg::ST_BAD_INDEX;
        end else begin
          rd_nxt = tmp_a_r;
        end
      end
      olst_pkg::F_SET: begin
        if (a_r >= olst_pkg::CAP_CNT) begin
          status_nxt = olst_pkg::ST_BAD_INDEX;
        end else begin
          ctrl.load0_en  = 1'b1;
          ctrl.load0_idx = a_r[olst_pkg::IDX_W-1:0];
          ctrl.load0_val = v_r;
          if (count_r <= a_r) begin
            count_nxt = a_r + olst_pkg::CNT_W'(1);
          end
        end
      end
      olst_pkg::F_INSERT: begin
        if (a_r > count_r) begin
          status_nxt = olst_pkg::ST_BAD_INDEX;
        end else if (count_r >= olst_pkg::CAP_CNT) begin
          status_nxt = olst_pkg::ST_FULL;
        end else begin
          // Shift up everything from the slot above the insert point.
          ctrl.take_left = 1'b1;
          ctrl.lo        = a_r + olst_pkg::CNT_W'(1);
          ctrl.hi_x      = count_r + olst_pkg::CNT_W'(1);
          ctrl.load0_en  = 1'b1;
          ctrl.load0_idx = a_r[olst_pkg::IDX_W-1:0];
          ctrl.load0_val = v_r;
          count_nxt      = count_r + olst_pkg::CNT_W'(1);
        end
      end
      olst_pkg::F_REMOVE: begin
        if (count_r == '0) begin
          status_nxt = olst_pkg::ST_EMPTY;
        end else if (a_r >= count_r) begin
          status_nxt = olst_pkg::ST_BAD_INDEX;
        end else begin
          rd_nxt          = tmp_a_r;
          ctrl.take_right = 1'b1;
          ctrl.lo         = a_r;
          ctrl.hi_x       = count_r - olst_pkg::CNT_W'(1);
          count_nxt       = count_r - olst_pkg::CNT_W'(1);
        end
      end
      olst_pkg::F_SWAP: begin
        if ((a_r >= count_r) || ({1'b0, b_r} >= count_r)) begin
          status_nxt = olst_pkg::ST_BAD_INDEX;
        end else begin
          ctrl.load0_en  = 1'b1;
          ctrl.load0_idx = a_r[olst_pkg::IDX_W-1:0];
          ctrl.load0_val = tmp_b_r;
          ctrl.load1_en  = 1'b1;
          ctrl.load1_idx = b_r;
          ctrl.load1_val = tmp_a_r;
        end
      end
      olst_pkg::F_MOVE: begin
        if ((a_r >= count_r) || ({1'b0, b_r} >= count_r)) begin
          status_nxt = olst_pkg::ST_BAD_INDEX;
        end else begin
          ctrl.load1_en  = 1'b1;
          ctrl.load1_idx = b_r;
          ctrl.load1_val = tmp_a_r;
          if (a_r < {1'b0, b_r}) begin
            // Source below destination: close the gap downward.
            ctrl.take_right = 1'b1;
            ctrl.lo         = a_r;
            ctrl.hi_x       = {1'b0, b_r};
          end else if ({1'b0, b_r} < a_r) begin
            ctrl.take_left = 1'b1;
            ctrl.lo        = {1'b0, b_r} + olst_pkg::CNT_W'(1);
            ctrl.hi_x      = a_r + olst_pkg::CNT_W'(1);
          end
        end
      end
      olst_pkg::F_FIND: begin
        if (hit_r) begin
          pos_nxt = hit_pos_r;
        end else begin
          status_nxt = olst_pkg::ST_NOT_FOUND;
        end
      end
      olst_pkg::F_SETCOUNT: begin
        if (a_r > olst_pkg::CAP_CNT) begin
          status_nxt = olst_pkg::ST_BAD_INDEX;
        end else begin
          count_nxt = a_r;
        end
      end
      olst_pkg::F_CLEAR: begin
        count_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      olst_pkg::S_IDLE: begin
        if (in_xfer) begin
          state_nxt = olst_pkg::S_GATHER;
        end
      end
      olst_pkg::S_GATHER:  state_nxt = olst_pkg::S_RESOLVE;
      olst_pkg::S_RESOLVE: state_nxt = olst_pkg::S_COMMIT;
      olst_pkg::S_COMMIT: begin
        if (commit_go) begin
          state_nxt = olst_pkg::S_IDLE;
        end
      end
      default: state_nxt = olst_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (commit_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= olst_pkg::S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (commit_go) begin
        count_r <= count_nxt;
      end
    end
  end

  // Payload registers: no reset.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      func_r <= olst_pkg::func_t'(in_func);
      a_r    <= in_first_index;
      b_r    <= in_second_index;
      v_r    <= in_elem_value;
      // Pop reads the last entry; everything else reads at the first index.
      if (olst_pkg::func_t'(in_func) == olst_pkg::F_POP) begin
        rda_r <= count_r - olst_pkg::CNT_W'(1);
      end else begin
        rda_r <= in_first_index;
      end
    end
    if (state_r == olst_pkg::S_RESOLVE) begin
      tmp_a_r   <= tmp_a_nxt;
      tmp_b_r   <= tmp_b_nxt;
      hit_r     <= hit_nxt;
      hit_pos_r <= hit_pos_nxt;
    end
    if (commit_go) begin
      status_r <= status_nxt;
      rd_r     <= rd_nxt;
      pos_r    <= pos_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_read_value  = rd_r;
  assign out_position    = pos_r;
  assign out_entry_total = count_r;

endmodule

// File: hw/rtl/olst_cell.sv
module olst_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [olst_pkg::IDX_W-1:0]    cell_idx,
  input  olst_pkg::cell_look_t          look,
  input  olst_pkg::cell_ctrl_t          ctrl,
  input  logic [olst_pkg::VALUE_W-1:0]  left_val,
  input  logic [olst_pkg::VALUE_W-1:0]  right_val,
  output logic [olst_pkg::VALUE_W-1:0]  val,
  output olst_pkg::cell_flags_t         flags
);

  logic [olst_pkg::VALUE_W-1:0] val_r;
  logic [olst_pkg::VALUE_W-1:0] val_nxt;
  logic [olst_pkg::CNT_W-1:0]   idx_ext;
  logic                         in_range;

  assign idx_ext  = {1'b0, cell_idx};
  assign in_range = (idx_ext >= ctrl.lo) && (idx_ext < ctrl.hi_x);

  always_comb begin
    flags.hit   = (val_r == look.key) && (idx_ext < look.count);
    flags.sel_a = (idx_ext == look.rda_idx);
    flags.sel_b = (cell_idx == look.rdb_idx);
  end

  always_comb begin
    val_nxt = val_r;
    if (ctrl.wr_en) begin
      if (in_range && ctrl.take_left) begin
        val_nxt = left_val;
      end
      if (in_range && ctrl.take_right) begin
        val_nxt = right_val;
      end
      if (ctrl.load0_en && (cell_idx == ctrl.load0_idx)) begin
        val_nxt = ctrl.load0_val;
      end
      if (ctrl.load1_en && (cell_idx == ctrl.load1_idx)) begin
        val_nxt = ctrl.load1_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= '0;
    end else begin
      val_r <= val_nxt;
    end
  end

  assign val = val_r;

endmodule

// File: hw/rtl/olst_group.sv
module olst_group (
  input  logic                                                clk,
  input  logic [olst_pkg::GROUP-1:0][olst_pkg::VALUE_W-1:0]   vals,
  input  olst_pkg::cell_flags_t [olst_pkg::GROUP-1:0]         flags,
  output olst_pkg::grp_res_t                                  res
);

  olst_pkg::grp_res_t res_r;
  olst_pkg::grp_res_t res_nxt;

  // Or the selected values; take the lowest hit.
  always_comb begin
    res_nxt = '0;
    for (int i = olst_pkg::GROUP - 1; i >= 0; i--) begin
      if (flags[i].sel_a) begin
        res_nxt.val_a = res_nxt.val_a | vals[i];
      end
      if (flags[i].sel_b) begin
        res_nxt.val_b = res_nxt.val_b | vals[i];
      end
      if (flags[i].hit) begin
        res_nxt.hit     = 1'b1;
        res_nxt.hit_pos = olst_pkg::GRP_IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign res = res_r;

endmodule

// File: bench/tb_ordered_list_engine_top.sv
`timescale 1ns / 100ps

module tb_ordered_list_engine_top;

  localparam int CLK_PERIOD       = 10;
  localparam int RESET_CYCLES     = 10;
  localparam int RANDOM_PER_PHASE = 160;
  localparam int DRAIN_CYCLES     = 8;
  localparam int WATCHDOG_NS      = 2_000_000;
  localparam int CAP              = olst_pkg::CAPACITY;
  localparam int MAX_FIRST        = 64;
  localparam int MAX_SECOND       = 63;

  // func codes outside the defined set; the block treats them as no-ops
  localparam logic [olst_pkg::FUNC_W-1:0] FUNC_SPARE_LO = 4'd11;
  localparam logic [olst_pkg::FUNC_W-1:0] FUNC_SPARE_HI = 4'd15;

  typedef struct packed {
    logic [olst_pkg::FUNC_W-1:0]  func;
    logic [olst_pkg::CNT_W-1:0]   first;
    logic [olst_pkg::IDX_W-1:0]   second;
    logic [olst_pkg::VALUE_W-1:0] value;
  } list_request_t;

  typedef struct packed {
    olst_pkg::status_t            status;
    logic [olst_pkg::VALUE_W-1:0] read_value;
    logic [olst_pkg::IDX_W-1:0]   position;
    logic [olst_pkg::CNT_W-1:0]   total;
  } list_result_t;

  typedef struct {
    list_request_t req;
    bit            known;
    list_result_t  want;
  } plan_row_t;

  logic                          clk             = 1'b0;
  logic                          rst_n           = 1'b0;
  logic                          in_valid        = 1'b0;
  logic                          in_stall;
  logic [olst_pkg::FUNC_W-1:0]   in_func         = '0;
  logic [olst_pkg::CNT_W-1:0]    in_first_index  = '0;
  logic [olst_pkg::IDX_W-1:0]    in_second_index = '0;
  logic [olst_pkg::VALUE_W-1:0]  in_elem_value   = '0;
  logic                          out_valid;
  logic                          out_stall       = 1'b0;
  logic [olst_pkg::STATUS_W-1:0] out_status;
  logic [olst_pkg::VALUE_W-1:0]  out_read_value;
  logic [olst_pkg::IDX_W-1:0]    out_position;
  logic [olst_pkg::CNT_W-1:0]    out_entry_total;

  // Shadow of the list contents and length, advanced once per accepted request.
  logic [olst_pkg::VALUE_W-1:0]  shadow_entries [olst_pkg::CAPACITY];
  int                            shadow_count    = 0;

  list_result_t                  pending_results [$];
  list_result_t                  head_result;
  plan_row_t                     directed_plan   [$];
  int                            error_count     = 0;
  int                            send_idle_pct   = 0;
  int                            recv_stall_pct  = 0;

  ordered_list_engine_top DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_func         (in_func),
    .in_first_index  (in_first_index),
    .in_second_index (in_second_index),
    .in_elem_value   (in_elem_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_read_value  (out_read_value),
    .out_position    (out_position),
    .out_entry_total (out_entry_total)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Apply one request to the shadow list and return the result it should give.
  // A failed request leaves the list untouched.
  function automatic list_result_t apply_request(input list_request_t rq);
    list_result_t                 res;
    logic [olst_pkg::VALUE_W-1:0] held;
    int                           a;
    int                           b;
    int                           n;
    int                           k;
    res = '{status: olst_pkg::ST_OK, read_value: '0, position: '0, total: '0};
    a = int'(rq.first);
    b = int'(rq.second);
    n = shadow_count;
    case (rq.func)
      olst_pkg::F_PUSH: begin
        if (n >= CAP) begin
          res.status = olst_pkg::ST_FULL;
        end else begin
          shadow_entries[n] = rq.value;
          res.position = olst_pkg::IDX_W'(n);
          n++;
        end
      end
      olst_pkg::F_POP: begin
        if (n == 0) begin
          res.status = olst_pkg::ST_EMPTY;
        end else begin
          n--;
          res.read_value = shadow_entries[n];
        end
      end
      olst_pkg::F_GET: begin
        if (a >= n) res.status = olst_pkg::ST_BAD_INDEX;
        else res.read_value = shadow_entries[a];
      end
      olst_pkg::F_SET: begin
        if (a >= CAP) begin
          res.status = olst_pkg::ST_BAD_INDEX;
        end else begin
          // writing past the end stretches the list; skipped slots keep old data
          shadow_entries[a] = rq.value;
          if (n <= a) n = a + 1;
        end
      end
      olst_pkg::F_INSERT: begin
        if (a > n) begin
          res.status = olst_pkg::ST_BAD_INDEX;
        end else if (n >= CAP) begin
          res.status = olst_pkg::ST_FULL;
        end else begin
          for (k = n; k > a; k--) shadow_entries[k] = shadow_entries[k - 1];
          shadow_entries[a] = rq.value;
          n++;
        end
      end
      olst_pkg::F_REMOVE: begin
        if (n == 0) begin
          res.status = olst_pkg::ST_EMPTY;
        end else if (a >= n) begin
          res.status = olst_pkg::ST_BAD_INDEX;
        end else begin
          res.read_value = shadow_entries[a];
          for (k = a; k + 1 < n; k++) shadow_entries[k] = shadow_entries[k + 1];
          n--;
        end
      end
      olst_pkg::F_SWAP: begin
        if (a >= n || b >= n) begin
          res.status = olst_pkg::ST_BAD_INDEX;
        end else begin
          held = shadow_entries[a];
          shadow_entries[a] = shadow_entries[b];
          shadow_entries[b] = held;
        end
      end
      olst_pkg::F_MOVE: begin
        if (a >= n || b >= n) begin
          res.status = olst_pkg::ST_BAD_INDEX;
        end else if (a < b) begin
          held = shadow_entries[a];
          for (k = a; k < b; k++) shadow_entries[k] = shadow_entries[k + 1];
          shadow_entries[b] = held;
        end else if (b < a) begin
          held = shadow_entries[a];
          for (k = a; k > b; k--) shadow_entries[k] = shadow_entries[k - 1];
          shadow_entries[b] = held;
        end
      end
      olst_pkg::F_FIND: begin
        // first match wins
        res.status = olst_pkg::ST_NOT_FOUND;
        for (k = 0; k < n && res.status != olst_pkg::ST_OK; k++) begin
          if (shadow_entries[k] == rq.value) begin
            res.status = olst_pkg::ST_OK;
            res.position = olst_pkg::IDX_W'(k);
          end
        end
      end
      olst_pkg::F_SETCOUNT: begin
        if (a > CAP) res.status = olst_pkg::ST_BAD_INDEX;
        else n = a;
      end
      olst_pkg::F_CLEAR: begin
        n = 0;
      end
      default: begin
      end
    endcase
    shadow_count = n;
    res.total = olst_pkg::CNT_W'(n);
    return res;
  endfunction

  // Mostly a legal index below limit, sometimes anything up to wild_hi.
  function automatic int pick_index(input int limit, input int wild_hi);
    if (limit > 0 && $urandom_range(0, 99) < 88) return $urandom_range(0, limit - 1);
    return $urandom_range(0, wild_hi);
  endfunction

  // Random request shaped by the current shadow length so that most requests
  // land on live entries and the list swings between empty and full.
  function automatic list_request_t random_request();
    list_request_t rq;
    int            roll;
    int            a;
    int            b;
    roll = $urandom_range(0, 99);
    a = pick_index(shadow_count, MAX_FIRST);
    b = pick_index(shadow_count, MAX_SECOND);
    // a narrow value pool now and then makes duplicates for find
    if ($urandom_range(0, 3) == 0) rq.value = olst_pkg::VALUE_W'($urandom_range(0, 7));
    else rq.value = olst_pkg::VALUE_W'($urandom());
    if (roll < 18) begin
      rq.func = olst_pkg::F_PUSH;
    end else if (roll < 26) begin
      rq.func = olst_pkg::F_POP;
    end else if (roll < 35) begin
      rq.func = olst_pkg::F_GET;
    end else if (roll < 42) begin
      rq.func = olst_pkg::F_SET;
      a = pick_index(shadow_count + 1, MAX_FIRST);
    end else if (roll < 54) begin
      rq.func = olst_pkg::F_INSERT;
      a = pick_index(shadow_count + 1, MAX_FIRST);
    end else if (roll < 64) begin
      rq.func = olst_pkg::F_REMOVE;
    end else if (roll < 72) begin
      rq.func = olst_pkg::F_SWAP;
    end else if (roll < 83) begin
      rq.func = olst_pkg::F_MOVE;
    end else if (roll < 94) begin
      rq.func = olst_pkg::F_FIND;
      if (shadow_count > 0 && $urandom_range(0, 9) < 7)
        rq.value = shadow_entries[$urandom_range(0, shadow_count - 1)];
    end else if (roll < 97) begin
      rq.func = olst_pkg::F_SETCOUNT;
      a = $urandom_range(0, MAX_FIRST);
    end else if (roll < 98) begin
      rq.func = olst_pkg::F_CLEAR;
    end else begin
      rq.func = olst_pkg::FUNC_W'($urandom_range(int'(FUNC_SPARE_LO), int'(FUNC_SPARE_HI)));
    end
    rq.first  = olst_pkg::CNT_W'(a);
    rq.second = olst_pkg::IDX_W'(b);
    return rq;
  endfunction

  function automatic void add_row(input logic [olst_pkg::FUNC_W-1:0] f, input int a,
                                  input int b, input logic [olst_pkg::VALUE_W-1:0] v,
                                  input bit known = 1'b0,
                                  input olst_pkg::status_t st = olst_pkg::ST_OK,
                                  input logic [olst_pkg::VALUE_W-1:0] rd = '0,
                                  input int pos = 0, input int tot = 0);
    plan_row_t row;
    row.req   = '{func: f, first: olst_pkg::CNT_W'(a), second: olst_pkg::IDX_W'(b),
                  value: v};
    row.known = known;
    row.want  = '{status: st, read_value: rd, position: olst_pkg::IDX_W'(pos),
                  total: olst_pkg::CNT_W'(tot)};
    directed_plan.push_back(row);
  endfunction

  // Rows with a typed-in result check against that; the rest against the shadow.
  function automatic void build_directed_plan();
    // empty list right after reset
    add_row(olst_pkg::F_POP,    0, 0, '0, 1'b1, olst_pkg::ST_EMPTY,     '0, 0, 0);
    add_row(olst_pkg::F_REMOVE, 0, 0, '0, 1'b1, olst_pkg::ST_EMPTY,     '0, 0, 0);
    add_row(olst_pkg::F_GET,    0, 0, '0, 1'b1, olst_pkg::ST_BAD_INDEX, '0, 0, 0);
    add_row(olst_pkg::F_FIND,   0, 0, '0, 1'b1, olst_pkg::ST_NOT_FOUND, '0, 0, 0);
    // grow it with value extremes
    add_row(olst_pkg::F_PUSH,   0, 0, 32'hFFFF_FFFF, 1'b1, olst_pkg::ST_OK, '0, 0, 1);
    add_row(olst_pkg::F_PUSH,   0, 0, '0,            1'b1, olst_pkg::ST_OK, '0, 1, 2);
    add_row(olst_pkg::F_INSERT, 0, 0, 32'h8000_0001, 1'b1, olst_pkg::ST_OK, '0, 0, 3);
    add_row(olst_pkg::F_INSERT, 4, 0, 32'h0000_0001, 1'b1, olst_pkg::ST_BAD_INDEX,
            '0, 0, 3);
    add_row(olst_pkg::F_INSERT, 3, 0, 32'h1234_5678);
    // reorder: both move directions, move onto itself
    add_row(olst_pkg::F_SWAP,   0,  3, '0);
    add_row(olst_pkg::F_MOVE,   3,  0, '0);
    add_row(olst_pkg::F_MOVE,   0,  3, '0);
    add_row(olst_pkg::F_MOVE,   2,  2, '0);
    add_row(olst_pkg::F_SWAP,   1, 63, '0, 1'b1, olst_pkg::ST_BAD_INDEX, '0, 0, 4);
    add_row(olst_pkg::F_MOVE,  63,  1, '0, 1'b1, olst_pkg::ST_BAD_INDEX, '0, 0, 4);
    add_row(olst_pkg::F_FIND,   0,  0, 32'hFFFF_FFFF);
    add_row(olst_pkg::F_REMOVE, 1,  0, '0);
    add_row(olst_pkg::F_REMOVE, 64, 0, '0, 1'b1, olst_pkg::ST_BAD_INDEX, '0, 0, 3);
    // set at the last slot fills the list; then the full cases
    add_row(olst_pkg::F_SET,   63,  0, 32'hA5A5_A5A5, 1'b1, olst_pkg::ST_OK, '0, 0, 64);
    add_row(olst_pkg::F_SET,   64,  0, '1, 1'b1, olst_pkg::ST_BAD_INDEX, '0, 0, 64);
    add_row(olst_pkg::F_PUSH,   0,  0, '1, 1'b1, olst_pkg::ST_FULL,      '0, 0, 64);
    add_row(olst_pkg::F_INSERT, 64, 63, '1, 1'b1, olst_pkg::ST_FULL,     '0, 0, 64);
    add_row(olst_pkg::F_POP,    0,  0, '0, 1'b1, olst_pkg::ST_OK, 32'hA5A5_A5A5, 0, 63);
    // raising the count exposes the popped value again
    add_row(olst_pkg::F_SETCOUNT, 64, 0, '0, 1'b1, olst_pkg::ST_OK, '0, 0, 64);
    add_row(olst_pkg::F_CLEAR,     0, 0, '0, 1'b1, olst_pkg::ST_OK, '0, 0, 0);
    add_row(FUNC_SPARE_HI,         0, 0, '1, 1'b1, olst_pkg::ST_OK, '0, 0, 0);
    add_row(olst_pkg::F_SETCOUNT,  6, 0, '0);
  endfunction

  // Present one request and hold it until the block takes it. Valid is only
  // dropped for an idle gap, so back-to-back transfers keep it high.
  task automatic drive_request(input list_request_t rq, input bit known,
                               input list_result_t want);
    list_result_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_func         <= rq.func;
    in_first_index  <= rq.first;
    in_second_index <= rq.second;
    in_elem_value   <= rq.value;
    // stall is read at the edge, before this step's register updates land
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = apply_request(rq);
    pending_results.push_back(known ? want : predicted);
  endtask

  function automatic void compare_field(input string name,
                                        input logic [olst_pkg::VALUE_W-1:0] want,
                                        input logic [olst_pkg::VALUE_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
      error_count++;
    end
  endfunction

  // Result side: check each transfer, then pick the stall for the next edge.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, got status %0d value %0h",
                 $time, out_status, out_read_value);
        error_count++;
      end else begin
        head_result = pending_results.pop_front();
        compare_field("status", olst_pkg::VALUE_W'(head_result.status),
                      olst_pkg::VALUE_W'(out_status));
        compare_field("read_value", head_result.read_value, out_read_value);
        compare_field("position", olst_pkg::VALUE_W'(head_result.position),
                      olst_pkg::VALUE_W'(out_position));
        compare_field("entry_total", olst_pkg::VALUE_W'(head_result.total),
                      olst_pkg::VALUE_W'(out_entry_total));
      end
    end
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  initial begin
    list_result_t no_result;
    no_result = '0;
    foreach (shadow_entries[i]) shadow_entries[i] = '0;
    build_directed_plan();

    // Hold reset, then release it and start sending.
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Phase 0: eager sender, often-stalling receiver. Phase 1: the reverse.
    // Phase 2: no idling at all, to run at full rate.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 34;
          recv_stall_pct = 76;
        end
        1: begin
          send_idle_pct  = 76;
          recv_stall_pct = 34;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      if (phase == 0) begin
        foreach (directed_plan[i])
          drive_request(directed_plan[i].req, directed_plan[i].known, directed_plan[i].want);
      end
      repeat (RANDOM_PER_PHASE) drive_request(random_request(), 1'b0, no_result);
    end
    in_valid <= 1'b0;

    // Drain outstanding results, then give the block time to show any extra one.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) $display("** ordered_list_engine_top: PASSED **");
    else $display("** ordered_list_engine_top: FAILED **");
    $finish;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #(WATCHDOG_NS);
    $display("** ordered_list_engine_top: FAILED **");
    $finish;
  end

endmodule
